FILE: sv/dss_pkg.sv
// shared types, constants and reset pattern for the drum step sequencer
package dss_pkg;

   localparam int STEPS  = 16;
   localparam int STEP_W = $clog2(STEPS);

   localparam logic [1:0] GATE_MAX = 2'd2;
   localparam logic [1:0] GATE_OFF = 2'd0;
   localparam logic [1:0] GATE_FULL = 2'd1;
   localparam logic [1:0] GATE_HALF = 2'd2;
   localparam logic [1:0] GATE_SHORT = 2'd3;

   localparam logic [7:0] RATE_MAX = 8'd255;
   localparam logic [7:0] RATE_MIN = 8'd1;

   localparam logic [15:0] ADDR_RATE     = 16'h00FD;
   localparam logic [15:0] ADDR_ACCENT   = 16'h00FE;
   localparam logic [15:0] ADDR_PLAY     = 16'h00FF;
   localparam logic [15:0] ADDR_STOP     = 16'h0100;
   localparam logic [15:0] ADDR_LENGTH   = 16'h0101;
   localparam logic [15:0] ADDR_LENGTH_H = 16'h0102;
   localparam logic [15:0] ADDR_START    = 16'h0103;
   localparam logic [15:0] ADDR_START_H  = 16'h0104;

   localparam logic REG_TICK_DIVIDE   = 1'b0;
   localparam logic REG_SAMPLE_LENGTH = 1'b1;

   localparam logic [7:0] TICK_DIVIDE_RESET = 8'd10;

   typedef enum logic [1:0] {
      COL_GATE   = 2'd0,
      COL_ACCENT = 2'd1,
      COL_RATE   = 2'd2,
      COL_STRAY  = 2'd3
   } column_type;

   typedef enum logic [2:0] {
      BEAT_STOP     = 3'd0,
      BEAT_ACCENT   = 3'd1,
      BEAT_START_L  = 3'd2,
      BEAT_START_H  = 3'd3,
      BEAT_LENGTH_L = 3'd4,
      BEAT_LENGTH_H = 3'd5,
      BEAT_RATE     = 3'd6,
      BEAT_PLAY     = 3'd7
   } beat_type;

   typedef struct packed {
      logic [1:0] gate;
      logic       accent;
      logic [7:0] rate;
   } entry_type;

   // pattern contents right after reset
   function automatic entry_type init_entry(input int idx);
      entry_type e;
      logic [7:0] r;
      case (idx % 16)
         0: r = 8'd20;
         1: r = 8'd21;
         2: r = 8'd22;
         3: r = 8'd30;
         4: r = 8'd29;
         5: r = 8'd28;
         6: r = 8'd10;
         7: r = 8'd12;
         8: r = 8'd14;
         9: r = 8'd15;
         10: r = 8'd13;
         11: r = 8'd11;
         12: r = 8'd9;
         13: r = 8'd8;
         14: r = 8'd7;
         default: r = 8'd6;
      endcase
      e.gate   = (idx == 0) ? GATE_FULL : GATE_OFF;
      e.accent = ((idx % 4) == 0);
      e.rate   = r;
      return e;
   endfunction

endpackage

FILE: sv/drum_step_sequencer.sv
// drum step sequencer top: button edits, frame divider, pattern memory and write runs
// a played step is loaded from the edit stage into the write emitter, which offers its first write
// throughput: one frame item per cycle while no run is pending; the output port sends one
// register write per cycle while rsp_tready is high; a played step's run is eight writes
// (four for gate three), and a following playing item waits behind it in the edit stage
// reset is synchronous and active high; the pattern reads back its power-up contents at once
module drum_step_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // down, up, left, right, a, 3 zero bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // write_address[15:0], write_data[23:16]
   output logic        rsp_tlast,   // run_last
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [dss_pkg::STEP_W-1:0] LAST_STEP = dss_pkg::STEP_W'(dss_pkg::STEPS - 1);

   logic [7:0]  tick_divide_ff;
   logic [15:0] sample_length_ff;

   logic [4:0]                 held_ff;
   logic [dss_pkg::STEP_W-1:0] cursor_ff;
   logic [dss_pkg::STEP_W-1:0] cursor_in;
   logic [dss_pkg::STEP_W-1:0] cursor_up;
   logic [dss_pkg::STEP_W-1:0] playhead_ff;
   logic [dss_pkg::STEP_W-1:0] playhead_in;
   dss_pkg::column_type        column_ff;
   dss_pkg::column_type        column_in;
   logic [7:0]                 phase_ff;
   logic [7:0]                 phase_in;
   logic [7:0]                 div_m1;
   logic [4:0]                 rise;
   logic                       accept;
   logic                       play_now;

   // edit stage
   logic                       b_vld_ff;
   logic                       b_lower_ff;
   logic                       b_raise_ff;
   logic                       b_play_ff;
   dss_pkg::column_type        b_col_ff;
   logic [dss_pkg::STEP_W-1:0] b_cur_ff;
   logic [dss_pkg::STEP_W-1:0] b_ph_ff;
   logic                       b_adv;
   logic                       b_run;
   logic                       edit_wr;
   dss_pkg::entry_type         cur_entry;
   dss_pkg::entry_type         ph_entry;
   dss_pkg::entry_type         low_entry;
   dss_pkg::entry_type         new_entry;
   dss_pkg::entry_type         play_entry;
   logic                       run_ready;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divide_ff   <= dss_pkg::TICK_DIVIDE_RESET;
         sample_length_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == dss_pkg::REG_TICK_DIVIDE) begin
            tick_divide_ff <= csr_wdata[7:0];
         end
         if (csr_index == dss_pkg::REG_SAMPLE_LENGTH) begin
            sample_length_ff <= csr_wdata;
         end
      end
   end

   assign rise = req_tdata[4:0] & ~held_ff;

   always_comb begin
      cursor_up = cursor_ff;
      if (rise[0]) begin
         cursor_up = (cursor_ff == LAST_STEP) ? '0 : cursor_ff + 1'b1;
      end
      cursor_in = cursor_up;
      if (rise[1]) begin
         cursor_in = (cursor_up == '0) ? LAST_STEP : cursor_up - 1'b1;
      end
   end

   always_comb begin
      column_in = column_ff;
      if (rise[4]) begin
         case (column_ff)
            dss_pkg::COL_GATE:   column_in = dss_pkg::COL_ACCENT;
            dss_pkg::COL_ACCENT: column_in = dss_pkg::COL_RATE;
            dss_pkg::COL_RATE:   column_in = dss_pkg::COL_GATE;
            dss_pkg::COL_STRAY:  column_in = dss_pkg::COL_ACCENT;
            default:             column_in = dss_pkg::COL_GATE;
         endcase
      end
   end

   // a zero divide plays every frame
   assign div_m1   = (tick_divide_ff == 8'd0) ? 8'd0 : tick_divide_ff - 8'd1;
   assign play_now = (phase_ff == 8'd0);
   assign phase_in = (phase_ff >= div_m1) ? 8'd0 : phase_ff + 8'd1;
   assign playhead_in = !play_now ? playhead_ff :
                        (playhead_ff == LAST_STEP) ? '0 : playhead_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         cursor_ff   <= '0;
         column_ff   <= dss_pkg::COL_GATE;
         phase_ff    <= '0;
         playhead_ff <= '0;
         b_vld_ff    <= 1'b0;
      end else begin
         if (accept) begin
            held_ff     <= req_tdata[4:0];
            cursor_ff   <= cursor_in;
            column_ff   <= column_in;
            phase_ff    <= phase_in;
            playhead_ff <= playhead_in;
            b_vld_ff    <= 1'b1;
         end else if (b_adv) begin
            b_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_lower_ff <= rise[2];
         b_raise_ff <= rise[3];
         b_col_ff   <= column_ff;
         b_cur_ff   <= cursor_in;
         b_ph_ff    <= playhead_ff;
         b_play_ff  <= play_now;
      end
   end

   dss_pattern_ram u_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_a_addr (cursor_in),
      .rd_b_addr (playhead_ff),
      .rd_a_data (cur_entry),
      .rd_b_data (ph_entry),
      .wr_en     (edit_wr),
      .wr_addr   (b_cur_ff),
      .wr_data   (new_entry)
   );

   // lower first, then raise, both on the column selected before this item
   always_comb begin
      low_entry = cur_entry;
      if (b_lower_ff) begin
         case (b_col_ff)
            dss_pkg::COL_GATE: begin
               if (cur_entry.gate != 2'd0) low_entry.gate = cur_entry.gate - 2'd1;
            end
            dss_pkg::COL_ACCENT: low_entry.accent = 1'b0;
            dss_pkg::COL_RATE: begin
               low_entry.rate = (cur_entry.rate > dss_pkg::RATE_MIN) ?
                                cur_entry.rate - 8'd1 : dss_pkg::RATE_MIN;
            end
            default: low_entry = cur_entry;
         endcase
      end
      new_entry = low_entry;
      if (b_raise_ff) begin
         case (b_col_ff)
            dss_pkg::COL_GATE: begin
               new_entry.gate = (low_entry.gate < dss_pkg::GATE_MAX) ?
                                low_entry.gate + 2'd1 : dss_pkg::GATE_MAX;
            end
            dss_pkg::COL_ACCENT: new_entry.accent = 1'b1;
            dss_pkg::COL_RATE: begin
               if (low_entry.rate < dss_pkg::RATE_MAX) new_entry.rate = low_entry.rate + 8'd1;
            end
            default: new_entry = low_entry;
         endcase
      end
   end

   // the played step sees this frame's edit
   assign play_entry = (b_cur_ff == b_ph_ff) ? new_entry : ph_entry;
   assign b_run      = b_play_ff && (play_entry.gate != dss_pkg::GATE_OFF);
   assign b_adv      = b_vld_ff && (!b_run || run_ready);
   assign edit_wr    = b_adv && (b_lower_ff || b_raise_ff);
   assign req_tready = !b_vld_ff || b_adv;

   dss_run_emitter u_emit (
      .clock         (clock),
      .reset         (reset),
      .run_valid     (b_vld_ff && b_run),
      .run_ready     (run_ready),
      .run_entry     (play_entry),
      .sample_length (sample_length_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

   a_last_is_play: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[15:0] == dss_pkg::ADDR_PLAY)
      else $error("run end not on play register");

   a_run_starts_stop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tdata[15:0] == dss_pkg::ADDR_STOP)
      else $error("run does not begin with stop write");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= LAST_STEP && playhead_ff <= LAST_STEP)
      else $error("cursor or playhead out of range");

   a_accept_loads_edit: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_vld_ff)
      else $error("accepted item missing from edit stage");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      edit_wr |-> req_tready)
      else $error("pattern written while edit stage stalled");

endmodule

FILE: sv/dss_pattern_ram.sv
// step pattern memory: two registered read ports, one write port, reset via valid bits
module dss_pattern_ram (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [dss_pkg::STEP_W-1:0] rd_a_addr,
   input  logic [dss_pkg::STEP_W-1:0] rd_b_addr,
   output dss_pkg::entry_type         rd_a_data,
   output dss_pkg::entry_type         rd_b_data,
   input  logic                       wr_en,
   input  logic [dss_pkg::STEP_W-1:0] wr_addr,
   input  dss_pkg::entry_type         wr_data
);

   dss_pkg::entry_type mem [dss_pkg::STEPS];
   logic [dss_pkg::STEPS-1:0] valid_ff;
   dss_pkg::entry_type rd_a_ff;
   dss_pkg::entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // write-first: a read of the entry being written returns the new value
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_a_addr) begin
            rd_a_ff <= wr_data;
         end else if (valid_ff[rd_a_addr]) begin
            rd_a_ff <= mem[rd_a_addr];
         end else begin
            rd_a_ff <= dss_pkg::init_entry(int'(rd_a_addr));
         end
         if (wr_en && wr_addr == rd_b_addr) begin
            rd_b_ff <= wr_data;
         end else if (valid_ff[rd_b_addr]) begin
            rd_b_ff <= mem[rd_b_addr];
         end else begin
            rd_b_ff <= dss_pkg::init_entry(int'(rd_b_addr));
         end
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: sv/dss_run_emitter.sv
// turns one played step into its run of sound register writes
module dss_run_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               run_valid,
   output logic               run_ready,
   input  dss_pkg::entry_type run_entry,
   input  logic [15:0]        sample_length,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // write_address[15:0], write_data[23:16]
   output logic               rsp_tlast    // run_last
);

   logic               busy_ff;
   logic               busy_in;
   dss_pkg::beat_type  beat_ff;
   dss_pkg::beat_type  beat_in;
   dss_pkg::entry_type run_ff;
   logic               load;
   logic               beat_done;
   logic [15:0]        half_len;
   logic [15:0]        start_val;
   logic [15:0]        len_val;
   logic [15:0]        addr;
   logic [7:0]         data;

   assign beat_done = busy_ff && rsp_tready;
   assign run_ready = !busy_ff || (rsp_tready && beat_ff == dss_pkg::BEAT_PLAY);
   assign load      = run_valid && run_ready;

   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (load) begin
         busy_in = 1'b1;
         beat_in = dss_pkg::BEAT_STOP;
      end else if (beat_done) begin
         if (beat_ff == dss_pkg::BEAT_PLAY) begin
            busy_in = 1'b0;
         end else if (beat_ff == dss_pkg::BEAT_ACCENT && run_ff.gate == dss_pkg::GATE_SHORT) begin
            // gate three has no start or length writes
            beat_in = dss_pkg::BEAT_RATE;
         end else begin
            beat_in = dss_pkg::beat_type'(beat_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= dss_pkg::BEAT_STOP;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= run_entry;
      end
   end

   assign half_len  = {1'b0, sample_length[15:1]};
   assign start_val = (run_ff.gate == dss_pkg::GATE_HALF) ? half_len - 16'd1 : 16'd0;
   assign len_val   = (run_ff.gate == dss_pkg::GATE_HALF) ? half_len : sample_length;

   always_comb begin
      case (beat_ff)
         dss_pkg::BEAT_STOP: begin
            addr = dss_pkg::ADDR_STOP;
            data = 8'd1;
         end
         dss_pkg::BEAT_ACCENT: begin
            addr = dss_pkg::ADDR_ACCENT;
            data = {7'd0, run_ff.accent};
         end
         dss_pkg::BEAT_START_L: begin
            addr = dss_pkg::ADDR_START;
            data = start_val[7:0];
         end
         dss_pkg::BEAT_START_H: begin
            addr = dss_pkg::ADDR_START_H;
            data = start_val[15:8];
         end
         dss_pkg::BEAT_LENGTH_L: begin
            addr = dss_pkg::ADDR_LENGTH;
            data = len_val[7:0];
         end
         dss_pkg::BEAT_LENGTH_H: begin
            addr = dss_pkg::ADDR_LENGTH_H;
            data = len_val[15:8];
         end
         dss_pkg::BEAT_RATE: begin
            addr = dss_pkg::ADDR_RATE;
            data = run_ff.rate;
         end
         dss_pkg::BEAT_PLAY: begin
            addr = dss_pkg::ADDR_PLAY;
            data = 8'd1;
         end
         default: begin
            addr = dss_pkg::ADDR_PLAY;
            data = 8'd1;
         end
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {data, addr};
   assign rsp_tlast  = (beat_ff == dss_pkg::BEAT_PLAY);

endmodule
